/* rtl/core/hhvr_pkg.sv */
// Shared types, codes and constant tables for the HTTP header value rewriter.
package hhvr_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_SCAN    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_NEXT     = 2'd0;
  localparam logic [1:0] ST_MODIFIED = 2'd1;
  localparam logic [1:0] ST_FINISH   = 2'd2;
  localparam logic [1:0] ST_RESET    = 2'd3;

  // Character constants.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_U     = 8'h55;

  localparam int unsigned CountW   = 10;
  localparam logic [9:0]  HeadLen  = 10'd12;
  localparam logic [9:0]  CountMax = 10'd1023;
  localparam logic [9:0]  EndLen   = 10'd4;
  localparam logic [9:0]  EndDone  = 10'd3;

  // Per-item result of the scanner, handed to the output pipeline.
  typedef struct packed {
    logic [1:0] status;
    logic       use_table;
    logic [9:0] pos;
  } scan_res_t;

  // Header name "User-Agent: ", one character per position.
  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h55; // U
      4'd1:    c = 8'h73; // s
      4'd2:    c = 8'h65; // e
      4'd3:    c = 8'h72; // r
      4'd4:    c = 8'h2D; // -
      4'd5:    c = 8'h41; // A
      4'd6:    c = 8'h67; // g
      4'd7:    c = 8'h65; // e
      4'd8:    c = 8'h6E; // n
      4'd9:    c = 8'h74; // t
      4'd10:   c = 8'h3A; // :
      4'd11:   c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // End of header marker CR LF CR LF.
  function automatic logic [7:0] end_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0, 2'd2: c = CHAR_CR;
      default:    c = CHAR_LF;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/hhvr_if.sv */
// Valid/ready channel interfaces for the input, output and configuration ports.
interface hhvr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [8:0] table_index;
  modport source (output valid, kind, data_byte, table_index, input ready);
  modport sink (input valid, kind, data_byte, table_index, output ready);
endinterface

interface hhvr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] scan_status;
  modport source (output valid, out_byte, scan_status, input ready);
  modport sink (input valid, out_byte, scan_status, output ready);
endinterface

interface hhvr_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] replacement_length;
  modport source (output valid, replacement_length, input ready);
  modport sink (input valid, replacement_length, output ready);
endinterface

/* rtl/core/hhvr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module hhvr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hhvr_scanner.sv */
// Scan state machine: header name match, value rewrite and end marker match.
module hhvr_scanner #(
  parameter int unsigned TableDepth = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  restart_i,
  input  logic [7:0]            byte_i,
  input  logic [9:0]            len_i,
  output hhvr_pkg::scan_res_t   res_o
);
  import hhvr_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_HEAD  = 2'd1;
  localparam logic [1:0] MODE_VALUE = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [1:0]  status;
  logic        retry;
  logic [10:0] len_m1;

  // Next state; a mismatch while matching falls back to idle and rechecks the byte.
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    status = ST_NEXT;
    retry  = 1'b0;
    case (mode_q)
      MODE_HEAD: begin
        if (cnt_q < HeadLen && byte_i == head_char(cnt_q[3:0])) begin
          cnt_d = cnt_q + 10'd1;
          if (cnt_d == HeadLen) begin
            mode_d = MODE_VALUE;
            cnt_d  = '0;
          end
        end else begin
          retry = 1'b1;
        end
      end
      MODE_VALUE: begin
        if (byte_i == CHAR_CR) begin
          mode_d = MODE_IDLE;
          status = ST_FINISH;
        end else begin
          status = ST_MODIFIED;
          if (cnt_q < CountMax) begin
            cnt_d = cnt_q + 10'd1;
          end
        end
      end
      MODE_END: begin
        if (cnt_q < EndLen && byte_i == end_char(cnt_q[1:0])) begin
          cnt_d = cnt_q + 10'd1;
          if (cnt_d == EndDone) begin
            mode_d = MODE_IDLE;
            status = ST_FINISH;
          end
        end else begin
          retry = 1'b1;
        end
      end
      default: begin
        retry = 1'b1;
      end
    endcase
    if (retry) begin
      mode_d = MODE_IDLE;
      if (byte_i == CHAR_U) begin
        mode_d = MODE_HEAD;
        cnt_d  = 10'd1;
      end else if (byte_i == CHAR_CR) begin
        mode_d = MODE_END;
        cnt_d  = 10'd1;
      end
    end
  end

  // Table lookup applies below length minus one and inside the table.
  assign len_m1 = {1'b0, len_i} - 11'd1;

  always_comb begin
    res_o.status    = status;
    res_o.pos       = cnt_q;
    res_o.use_table = (mode_q == MODE_VALUE) && (byte_i != CHAR_CR) &&
                      (len_i != '0) && ({1'b0, cnt_q} < len_m1) &&
                      (32'(cnt_q) < TableDepth);
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (restart_i) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // While the header name matches, the count points inside the name.
  a_head_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HEAD |-> (cnt_q >= 10'd1 && cnt_q < HeadLen))
    else $error("header match count out of range");

  // The end marker finishes at its third byte, so the count stays at one or two.
  a_end_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_END |-> (cnt_q == 10'd1 || cnt_q == 10'd2))
    else $error("end marker count out of range");

  // A restart always leaves the scanner idle with a zero count.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (mode_q == MODE_IDLE && cnt_q == '0))
    else $error("restart did not clear the scanner");

endmodule

/* rtl/core/http_header_value_rewriter_core.sv */
// Top level of the HTTP header value rewriter: channels, table RAM and output pipeline.
//
// Usage:
//   in_i carries one item per handshake: kind 0 scans a stream byte, kind 1 writes
//   data_byte into the replacement table at table_index, kind 2 restarts the scanner.
//   out_o returns exactly one item per input item, in order: the byte after any
//   rewrite and a status (continue, modified, finished, scanner reset). cfg_i is always
//   ready; the user must write replacement_length only while idle (unchecked).
// Timing:
//   One item per cycle sustained while out_o.ready holds. The accepting edge updates
//   the scan state, starts the registered read of the replacement table RAM and loads
//   the read stage; the output register loads from the read stage when free or taken.
//   A byte and its successor never wait on each other.
// Reset and stalls:
//   Reset returns the scanner to idle with a zero count and clears the length;
//   the table contents are undefined until written. When the receiver stalls, the
//   output register and the read stage hold, and in_i.ready drops once both are full.
module http_header_value_rewriter_core #(
  parameter int unsigned TABLE_DEPTH = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hhvr_in_if.sink   in_i,
  hhvr_out_if.source out_o,
  hhvr_cfg_if.sink  cfg_i
);
  import hhvr_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned ExtW  = AddrW + 10;

  logic [9:0]      len_q;
  scan_res_t       res;
  logic            in_ready;
  logic            accept;
  logic            s1_adv;
  logic            ram_we;
  logic            ram_re;
  logic [ExtW-1:0] widx_ext;
  logic [ExtW-1:0] rpos_ext;
  logic [7:0]      rdata;

  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic [1:0]      s1_status_q;
  logic            s1_use_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic [1:0]      out_status_q;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_i.valid) begin
      len_q <= cfg_i.replacement_length;
    end
  end

  // Handshake: the read stage moves on whenever the output register is free or being taken.
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  hhvr_scanner #(
    .TableDepth (TABLE_DEPTH)
  ) u_scanner (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept && in_i.kind == KIND_SCAN),
    .restart_i (accept && in_i.kind == KIND_RESTART),
    .byte_i    (in_i.data_byte),
    .len_i     (len_q),
    .res_o     (res)
  );

  // Replacement table RAM; a read sees a write made to the same entry by an earlier item.
  assign widx_ext = ExtW'(in_i.table_index);
  assign rpos_ext = ExtW'(res.pos);
  assign ram_we   = accept && in_i.kind == KIND_WRITE &&
                    (32'(in_i.table_index) < TABLE_DEPTH);
  assign ram_re   = accept && in_i.kind == KIND_SCAN && res.use_table;

  hhvr_ram #(
    .Width (8),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_ext[AddrW-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (rpos_ext[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Read stage: holds the status and the fallback byte while the RAM read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_use_q <= ram_re;
      if (in_i.kind == KIND_SCAN) begin
        s1_status_q <= res.status;
        s1_byte_q   <= (res.status == ST_MODIFIED) ? CHAR_SPACE : in_i.data_byte;
      end else if (in_i.kind == KIND_RESTART) begin
        s1_status_q <= ST_RESET;
        s1_byte_q   <= in_i.data_byte;
      end else begin
        s1_status_q <= ST_NEXT;
        s1_byte_q   <= in_i.data_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q   <= s1_use_q ? rdata : s1_byte_q;
      out_status_q <= s1_status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.scan_status = out_status_q;

  // A read stage item that cannot move on must still be there next cycle.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("read stage item lost while stalled");

  // The table read data must not change under a waiting item that uses it.
  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv && s1_use_q |=> $stable(rdata))
    else $error("table read data changed under a stalled item");

  // An accepted item always finds room in the read stage.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!s1_valid_q || s1_adv))
    else $error("read stage overrun");

endmodule
